### hdl/wtbs_pkg.sv
// ----------------------------------------------------------------------------
// Wavetable bilinear sampler: shared definitions
// Command codes, step codes of the four table reads, the beat that travels
// with each read result, and the fixed-point linear blend used by the datapath.
// ----------------------------------------------------------------------------
package wtbs_pkg;

    // Command codes carried by an s_ beat.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Order in which the four neighbouring samples are read.
    localparam logic [1:0] STEP_S00 = 2'd0;  // lower frame, lower sample
    localparam logic [1:0] STEP_S01 = 2'd1;  // lower frame, upper sample
    localparam logic [1:0] STEP_S10 = 2'd2;  // upper frame, lower sample
    localparam logic [1:0] STEP_S11 = 2'd3;  // upper frame, upper sample

    // Tag carried alongside a table read result.
    typedef struct packed {
        logic        valid;
        logic [1:0]  step;
        logic [15:0] sfrac;
        logic [15:0] ffrac;
    } rd_beat_t;

    // a + floor(f * (b - a) / 65536). The result always lies between a and b,
    // so it fits in 16 bits without saturation.
    function automatic logic signed [15:0] lerp(
        input logic signed [15:0] a,
        input logic signed [15:0] b,
        input logic        [15:0] f
    );
        logic signed [16:0] diff;
        logic signed [16:0] fs;
        logic signed [33:0] prod;
        logic signed [17:0] quot;
        logic signed [17:0] sum;
        diff = {b[15], b} - {a[15], a};
        fs   = {1'b0, f};
        prod = diff * fs;
        // Taking the upper bits of a two's complement product floors it.
        quot = prod[33:16];
        sum  = {{2{a[15]}}, a} + quot;
        return sum[15:0];
    endfunction

endpackage

### hdl/wtbs_blend.sv
// ----------------------------------------------------------------------------
// Wavetable bilinear sampler: blend datapath
// Takes the four table samples of one output as they return from memory and
// blends them, first across the phase within each frame, then across frames.
// ----------------------------------------------------------------------------
module wtbs_blend (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  wtbs_pkg::rd_beat_t    rd_beat,
    input  logic signed [15:0]    rd_data,
    output logic                  res_valid,
    output logic signed [15:0]    res_sample
);

    logic signed [15:0] lo_reg;
    logic signed [15:0] s0_reg;
    logic signed [15:0] s1_reg;
    logic        [15:0] ffrac_reg;
    logic signed [15:0] mix;
    logic               fin_valid_reg;
    logic               fin_valid_next;

    // One blender serves both frames: the lower sample of a pair is held
    // until its partner arrives.
    assign mix = wtbs_pkg::lerp(lo_reg, rd_data, rd_beat.sfrac);

    always_ff @(posedge aclk) begin
        if (rd_beat.valid) begin
            unique case (rd_beat.step)
                wtbs_pkg::STEP_S00, wtbs_pkg::STEP_S10: begin
                    lo_reg <= rd_data;
                end
                wtbs_pkg::STEP_S01: begin
                    s0_reg <= mix;
                end
                wtbs_pkg::STEP_S11: begin
                    s1_reg    <= mix;
                    ffrac_reg <= rd_beat.ffrac;
                end
            endcase
        end
    end

    // A result is ready once the upper frame has been blended.
    assign fin_valid_next = rd_beat.valid && (rd_beat.step == wtbs_pkg::STEP_S11);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else begin
            fin_valid_reg <= fin_valid_next;
        end
    end

    // Final blend across the morph position.
    assign res_valid  = fin_valid_reg;
    assign res_sample = wtbs_pkg::lerp(s0_reg, s1_reg, ffrac_reg);

endmodule

### hdl/wavetable_bilinear_sampler.sv
// ----------------------------------------------------------------------------
// Wavetable bilinear sampler
// Wavetable oscillator read stage: loads Q1.15 samples into a table store and
// produces bilinearly interpolated samples across phase and morph position.
// ----------------------------------------------------------------------------
// Usage
// The s_ channel carries commands. A load beat (cmd 0) writes load_value into
// table table_sel, frame load_frame, index load_index; out-of-range loads are
// dropped and give no result. A sample beat (cmd 1) gives exactly one beat on
// the m_ channel with the interpolated sample_out.
// A sample beat makes four reads, one after another, through the single
// port of the table memory; a load beat makes one write. Beats are
// accepted while earlier ones are still being read or blended.
// Results wait in a two-entry output buffer. When the receiver stalls, reads
// for a new sample beat are held back once two results are owed, and the
// input channel then backs up through the preparation stages.
// Reset clears all control state. The table memory is not cleared: its
// contents are undefined until written, and only written entries may be read.
// ----------------------------------------------------------------------------
module wavetable_bilinear_sampler #(
    parameter int NUM_TABLES    = 4,
    parameter int NUM_FRAMES    = 64,
    parameter int FRAME_SAMPLES = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic [2:0]         s_table_sel,
    input  logic [5:0]         s_load_frame,
    input  logic [7:0]         s_load_index,
    input  logic signed [15:0] s_load_value,
    input  logic signed [17:0] s_position,
    input  logic signed [31:0] s_phase,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_sample_out
);

    localparam int TABLE_SIZE = NUM_FRAMES * FRAME_SAMPLES;
    localparam int DEPTH      = NUM_TABLES * TABLE_SIZE;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int FRAME_W    = $clog2(NUM_FRAMES);
    localparam int SAMPLE_W   = $clog2(FRAME_SAMPLES);
    localparam int FPOS_W     = 16 + FRAME_W;
    localparam int SPOS_W     = 16 + SAMPLE_W;

    localparam logic [16:0] POS_ONE    = 17'd65536;
    localparam int          OUT_DEPTH  = 2;
    localparam logic [1:0]  PEND_MAX   = 2'(OUT_DEPTH);

    // ------------------------------------------------------------------
    // Stage 1: input register, table fallback, position clamp
    // ------------------------------------------------------------------
    logic               s1_valid_reg, s1_valid_next;
    logic               s1_cmd_reg;
    logic               s1_load_ok_reg;
    logic [2:0]         s1_tsel_reg;
    logic [5:0]         s1_lframe_reg;
    logic [7:0]         s1_lindex_reg;
    logic signed [15:0] s1_value_reg;
    logic [16:0]        s1_pos_reg;
    logic [15:0]        s1_frac_reg;

    logic        tsel_ok;
    logic        load_ok;
    logic [16:0] pos_clamped;
    logic        s_accept;
    logic        s1_ready;
    logic        s1_adv;

    logic        s2_ready;
    logic        iss_accept;

    assign tsel_ok = 32'(s_table_sel) < 32'(NUM_TABLES);
    assign load_ok = tsel_ok && (32'(s_load_frame) < 32'(NUM_FRAMES))
                             && (32'(s_load_index) < 32'(FRAME_SAMPLES));

    // Clamp the morph position to 0..1.
    always_comb begin
        if (s_position[17]) begin
            pos_clamped = '0;
        end else if (s_position > 18'sd65536) begin
            pos_clamped = POS_ONE;
        end else begin
            pos_clamped = s_position[16:0];
        end
    end

    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s1_adv   = s1_valid_reg && s2_ready;
    assign s_ready  = s1_ready;
    assign s_accept = s_valid && s1_ready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_cmd_reg     <= s_cmd;
            s1_load_ok_reg <= load_ok;
            s1_tsel_reg    <= tsel_ok ? s_table_sel : 3'd0;
            s1_lframe_reg  <= s_load_frame;
            s1_lindex_reg  <= s_load_index;
            s1_value_reg   <= s_load_value;
            s1_pos_reg     <= pos_clamped;
            // Only the fraction of the phase matters; this wraps negatives.
            s1_frac_reg    <= s_phase[15:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: frame and sample positions, table base
    // ------------------------------------------------------------------
    logic                s2_valid_reg, s2_valid_next;
    logic                s2_cmd_reg;
    logic                s2_load_ok_reg;
    logic [ADDR_W-1:0]   s2_base_reg;
    logic [ADDR_W-1:0]   s2_lf_off_reg;
    logic [7:0]          s2_lindex_reg;
    logic signed [15:0]  s2_value_reg;
    logic [FRAME_W-1:0]  s2_flo_reg;
    logic [15:0]         s2_ffrac_reg;
    logic [SAMPLE_W-1:0] s2_slo_reg;
    logic [15:0]         s2_sfrac_reg;

    logic [FPOS_W-1:0]   fpos;
    logic [SPOS_W-1:0]   spos;
    logic [ADDR_W-1:0]   base;
    logic [ADDR_W-1:0]   lf_off;
    logic                s2_adv;

    // Both products stay below their widths, so the integer parts are
    // always in range and need no clamp.
    assign fpos   = FPOS_W'(s1_pos_reg) * FPOS_W'(NUM_FRAMES - 1);
    assign spos   = SPOS_W'(s1_frac_reg) * SPOS_W'(FRAME_SAMPLES);
    assign base   = ADDR_W'(s1_tsel_reg) * ADDR_W'(TABLE_SIZE);
    assign lf_off = ADDR_W'(s1_lframe_reg) * ADDR_W'(FRAME_SAMPLES);

    assign s2_ready = !s2_valid_reg || iss_accept;
    assign s2_adv   = s2_valid_reg && iss_accept;

    always_comb begin
        s2_valid_next = s2_valid_reg;
        if (s1_adv) begin
            s2_valid_next = 1'b1;
        end else if (s2_adv) begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            s2_cmd_reg     <= s1_cmd_reg;
            s2_load_ok_reg <= s1_load_ok_reg;
            s2_base_reg    <= base;
            s2_lf_off_reg  <= lf_off;
            s2_lindex_reg  <= s1_lindex_reg;
            s2_value_reg   <= s1_value_reg;
            s2_flo_reg     <= fpos[FPOS_W-1:16];
            s2_ffrac_reg   <= fpos[15:0];
            s2_slo_reg     <= spos[SPOS_W-1:16];
            s2_sfrac_reg   <= spos[15:0];
        end
    end

    // ------------------------------------------------------------------
    // Issue stage: row addresses, then, if credit allows, one access per cycle
    // ------------------------------------------------------------------
    logic                iss_valid_reg, iss_valid_next;
    logic [1:0]          iss_step_reg, iss_step_next;
    logic                iss_cmd_reg;
    logic                iss_load_ok_reg;
    logic [ADDR_W-1:0]   iss_laddr_reg;
    logic signed [15:0]  iss_value_reg;
    logic [ADDR_W-1:0]   iss_row_lo_reg;
    logic [ADDR_W-1:0]   iss_row_hi_reg;
    logic [SAMPLE_W-1:0] iss_slo_reg;
    logic [SAMPLE_W-1:0] iss_shi_reg;
    logic [15:0]         iss_sfrac_reg;
    logic [15:0]         iss_ffrac_reg;

    logic [ADDR_W-1:0]   row_off;
    logic [ADDR_W-1:0]   row_lo;
    logic [ADDR_W-1:0]   row_hi;
    logic                frame_last;
    logic [SAMPLE_W-1:0] shi;
    logic [ADDR_W-1:0]   laddr;
    logic                is_load;
    logic                credit_ok;
    logic                seq_step;
    logic                seq_done;
    logic                seq_start;
    logic                mem_we;
    logic                mem_re;
    logic [ADDR_W-1:0]   raddr;

    // The upper frame is clamped to the last; the upper sample wraps to 0.
    assign row_off    = ADDR_W'(s2_flo_reg) * ADDR_W'(FRAME_SAMPLES);
    assign row_lo     = s2_base_reg + row_off;
    assign frame_last = s2_flo_reg == FRAME_W'(NUM_FRAMES - 1);
    assign row_hi     = row_lo + (frame_last ? '0 : ADDR_W'(FRAME_SAMPLES));
    assign shi        = (s2_slo_reg == SAMPLE_W'(FRAME_SAMPLES - 1)) ?
                        '0 : s2_slo_reg + SAMPLE_W'(1);
    assign laddr      = s2_base_reg + s2_lf_off_reg + ADDR_W'(s2_lindex_reg);

    // A sample beat starts its reads only when its result has a place to go.
    logic [1:0] pend_reg, pend_next;
    logic       pop;

    assign credit_ok = (pend_reg < PEND_MAX) || pop;
    assign is_load   = iss_cmd_reg == wtbs_pkg::CMD_LOAD;
    assign seq_step  = iss_valid_reg &&
                       (is_load || (iss_step_reg != wtbs_pkg::STEP_S00) || credit_ok);
    assign seq_done  = seq_step && (is_load || (iss_step_reg == wtbs_pkg::STEP_S11));
    assign seq_start = seq_step && !is_load && (iss_step_reg == wtbs_pkg::STEP_S00);
    assign iss_accept = !iss_valid_reg || seq_done;

    assign mem_we = iss_valid_reg && is_load && iss_load_ok_reg;
    assign mem_re = seq_step && (iss_cmd_reg == wtbs_pkg::CMD_SAMPLE);

    always_comb begin
        unique case (iss_step_reg)
            wtbs_pkg::STEP_S00: raddr = iss_row_lo_reg + ADDR_W'(iss_slo_reg);
            wtbs_pkg::STEP_S01: raddr = iss_row_lo_reg + ADDR_W'(iss_shi_reg);
            wtbs_pkg::STEP_S10: raddr = iss_row_hi_reg + ADDR_W'(iss_slo_reg);
            wtbs_pkg::STEP_S11: raddr = iss_row_hi_reg + ADDR_W'(iss_shi_reg);
        endcase
    end

    always_comb begin
        iss_valid_next = iss_valid_reg;
        iss_step_next  = iss_step_reg;
        if (iss_accept) begin
            iss_valid_next = s2_valid_reg;
        end
        if (seq_done) begin
            iss_step_next = wtbs_pkg::STEP_S00;
        end else if (seq_step) begin
            iss_step_next = iss_step_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv) begin
            iss_cmd_reg     <= s2_cmd_reg;
            iss_load_ok_reg <= s2_load_ok_reg;
            iss_laddr_reg   <= laddr;
            iss_value_reg   <= s2_value_reg;
            iss_row_lo_reg  <= row_lo;
            iss_row_hi_reg  <= row_hi;
            iss_slo_reg     <= s2_slo_reg;
            iss_shi_reg     <= shi;
            iss_sfrac_reg   <= s2_sfrac_reg;
            iss_ffrac_reg   <= s2_ffrac_reg;
        end
    end

    // ------------------------------------------------------------------
    // Table memory: one write or one read per cycle, registered read data
    // ------------------------------------------------------------------
    logic signed [15:0] table_mem [DEPTH];
    logic signed [15:0] rdata_reg;
    wtbs_pkg::rd_beat_t rd_beat_reg, rd_beat_next;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[iss_laddr_reg] <= iss_value_reg;
        end
        if (mem_re) begin
            rdata_reg <= table_mem[raddr];
        end
    end

    always_comb begin
        rd_beat_next.valid = mem_re;
        rd_beat_next.step  = iss_step_reg;
        rd_beat_next.sfrac = iss_sfrac_reg;
        rd_beat_next.ffrac = iss_ffrac_reg;
    end

    // ------------------------------------------------------------------
    // Blend of the four samples
    // ------------------------------------------------------------------
    logic               res_valid;
    logic signed [15:0] res_sample;

    wtbs_blend u_blend (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_beat    (rd_beat_reg),
        .rd_data    (rdata_reg),
        .res_valid  (res_valid),
        .res_sample (res_sample)
    );

    // ------------------------------------------------------------------
    // Output buffer and count of results owed
    // ------------------------------------------------------------------
    logic signed [15:0] out_buf_reg [OUT_DEPTH];
    logic               out_wr_reg, out_wr_next;
    logic               out_rd_reg, out_rd_next;
    logic [1:0]         out_cnt_reg, out_cnt_next;

    assign m_valid      = out_cnt_reg != 2'd0;
    assign m_sample_out = out_buf_reg[out_rd_reg];
    assign pop          = m_valid && m_ready;

    always_comb begin
        out_wr_next  = out_wr_reg ^ res_valid;
        out_rd_next  = out_rd_reg ^ pop;
        out_cnt_next = out_cnt_reg + 2'(res_valid) - 2'(pop);
        pend_next    = pend_reg + 2'(seq_start) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_buf_reg[out_wr_reg] <= res_sample;
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            iss_valid_reg     <= 1'b0;
            iss_step_reg      <= wtbs_pkg::STEP_S00;
            out_wr_reg        <= 1'b0;
            out_rd_reg        <= 1'b0;
            out_cnt_reg       <= 2'd0;
            pend_reg          <= 2'd0;
        end else begin
            s1_valid_reg      <= s1_valid_next;
            s2_valid_reg      <= s2_valid_next;
            iss_valid_reg     <= iss_valid_next;
            iss_step_reg      <= iss_step_next;
            out_wr_reg        <= out_wr_next;
            out_rd_reg        <= out_rd_next;
            out_cnt_reg       <= out_cnt_next;
            pend_reg          <= pend_next;
        end
    end

    // The read beat's valid bit is reset; its tag fields follow the data.
    always_ff @(posedge aclk) begin
        rd_beat_reg.step  <= rd_beat_next.step;
        rd_beat_reg.sfrac <= rd_beat_next.sfrac;
        rd_beat_reg.ffrac <= rd_beat_next.ffrac;
        if (!aresetn) begin
            rd_beat_reg.valid <= 1'b0;
        end else begin
            rd_beat_reg.valid <= rd_beat_next.valid;
        end
    end

endmodule
